@@ rtl/core/scf_pkg.sv @@
// Shared types and constants of the session cache table.
package scf_pkg;

    localparam int OP_W      = 2;
    localparam int KLEN_W    = 6;
    localparam int DLEN_W    = 10;
    localparam int WORD_W    = 64;
    localparam int STAT_W    = 2;
    localparam int BEAT_W    = 6;
    localparam int KEY_WORDS = 4;
    localparam int KEY_BYTES = 32;
    localparam int KEY_BITS  = KEY_WORDS * WORD_W;

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_SIZE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] key_word0;
        logic [WORD_W-1:0] key_word1;
        logic [WORD_W-1:0] key_word2;
        logic [WORD_W-1:0] key_word3;
        logic [KLEN_W-1:0] key_len;
        logic [DLEN_W-1:0] payload_len;
        logic [WORD_W-1:0] payload_word;
        logic              beat_last;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] out_word;
        logic [DLEN_W-1:0] out_len;
        logic              result_last;
    } t_out_item;

    typedef enum logic [2:0] {
        K_BEAT,
        K_COMMIT,
        K_ERR,
        K_MISS,
        K_FETCH,
        K_DELETE
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [KEY_BITS-1:0]  key;
        logic [KEY_BYTES-1:0] byte_mask;
        logic [KLEN_W-1:0]    key_len;
        logic [DLEN_W-1:0]    payload_len;
        logic [WORD_W-1:0]    word;
    } t_cmd;

    typedef struct packed {
        logic [KLEN_W-1:0] klen;
        logic [DLEN_W-1:0] dlen;
    } t_sizes;

endpackage

@@ rtl/core/scf_in_if.sv @@
// Input channel: request words with valid/ready handshake.
interface scf_in_if;
    logic              valid;
    logic              ready;
    scf_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/scf_out_if.sv @@
// Output channel: result words with valid/ready handshake.
interface scf_out_if;
    logic               valid;
    logic               ready;
    scf_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/session_cache_fifo_table.sv @@
// Keyed session table with round-robin replacement: top level.
// A lookup scans the slots in order from slot 0; a miss scans them all, and a lookup
// with an oversized key answers a miss without a scan. A fetch hit with data streams one
// word per cycle while the result queue has room. Throughput: one store beat per cycle
// while the result queue has room; a lookup holds the back end until its results queue.
// Reset: synchronous; slot valid bits clear, with no memory clearing pass.
module session_cache_fifo_table #(
    parameter int ENTRIES        = 16,
    parameter int MAX_KEY_BYTES  = 32,
    parameter int MAX_DATA_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scf_in_if.sink    i_in,
    scf_out_if.source o_out
);

    logic          push;
    logic          full;
    logic          pop;
    logic          cmd_vld;
    scf_pkg::t_cmd front_cmd;
    scf_pkg::t_cmd back_cmd;

    scf_front #(
        .MAX_KEY_BYTES  (MAX_KEY_BYTES),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    scf_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_vld),
        .o_cmd   (back_cmd)
    );

    scf_back #(
        .ENTRIES        (ENTRIES),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (back_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ rtl/core/scf_front.sv @@
// Front end: accepts request words, checks sizes and builds commands.
module scf_front #(
    parameter int MAX_KEY_BYTES  = 32,
    parameter int MAX_DATA_BYTES = 512
) (
    scf_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output scf_pkg::t_cmd   o_cmd
);

    logic c_ksz_err;
    logic c_dsz_err;
    logic c_keep;

    assign i_in.ready = !i_full;

    always_comb begin
        c_ksz_err = i_in.payload.key_len > scf_pkg::KLEN_W'(MAX_KEY_BYTES);
        c_dsz_err = i_in.payload.payload_len > scf_pkg::DLEN_W'(MAX_DATA_BYTES);

        o_cmd.key         = {i_in.payload.key_word3, i_in.payload.key_word2,
                             i_in.payload.key_word1, i_in.payload.key_word0};
        o_cmd.key_len     = i_in.payload.key_len;
        o_cmd.payload_len = i_in.payload.payload_len;
        o_cmd.word        = i_in.payload.payload_word;
        for (int b = 0; b < scf_pkg::KEY_BYTES; b++) begin
            o_cmd.byte_mask[b] = scf_pkg::KLEN_W'(b) < i_in.payload.key_len;
        end

        o_cmd.kind = scf_pkg::K_MISS;
        c_keep     = 1'b0;
        unique case (i_in.payload.operation)
            scf_pkg::OP_STORE: begin
                if (c_ksz_err || c_dsz_err) begin
                    // oversized store: only the last beat reaches the back end
                    o_cmd.kind = scf_pkg::K_ERR;
                    c_keep     = i_in.payload.beat_last;
                end else begin
                    o_cmd.kind = i_in.payload.beat_last ? scf_pkg::K_COMMIT : scf_pkg::K_BEAT;
                    c_keep     = 1'b1;
                end
            end
            scf_pkg::OP_FETCH: begin
                o_cmd.kind = c_ksz_err ? scf_pkg::K_MISS : scf_pkg::K_FETCH;
                c_keep     = 1'b1;
            end
            scf_pkg::OP_DELETE: begin
                o_cmd.kind = c_ksz_err ? scf_pkg::K_MISS : scf_pkg::K_DELETE;
                c_keep     = 1'b1;
            end
            default: c_keep = 1'b0;
        endcase

        o_push = i_in.valid && !i_full && c_keep;
    end

endmodule

@@ rtl/core/scf_cmd_fifo.sv @@
// Short command queue between the front and back ends.
module scf_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output scf_pkg::t_cmd o_cmd
);

    localparam int PTR_W = $clog2(scf_pkg::CMD_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    scf_pkg::t_cmd    r_mem [scf_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(scf_pkg::CMD_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + PTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

@@ rtl/core/scf_back.sv @@
// Back end: table storage, key scan, data streaming and result queue.
module scf_back #(
    parameter int ENTRIES        = 16,
    parameter int MAX_DATA_BYTES = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  scf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    scf_out_if.source     o_out
);

    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int DATA_WORDS = (MAX_DATA_BYTES + 7) / 8;
    localparam int DW_W       = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int DATA_DEPTH = ENTRIES * (1 << DW_W);
    localparam int NW_W       = scf_pkg::BEAT_W + 1;
    localparam int ODEPTH     = scf_pkg::OUT_DEPTH;
    localparam int OPTR_W     = $clog2(ODEPTH);
    localparam int OCNT_W     = OPTR_W + 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_STREAM} t_state;

    // storage
    logic [scf_pkg::KEY_BITS-1:0] key_mem  [ENTRIES];
    scf_pkg::t_sizes              size_mem [ENTRIES];
    logic [scf_pkg::WORD_W-1:0]   data_mem [DATA_DEPTH];
    logic [ENTRIES-1:0]           r_vld, n_vld;

    // control
    t_state                       r_state, n_state;
    logic [SLOT_W-1:0]            r_wslot, n_wslot;
    logic [scf_pkg::BEAT_W-1:0]   r_beat, n_beat;
    logic [SLOT_W-1:0]            r_idx, n_idx;
    logic                         r_issue, n_issue;
    logic                         r_cmp_v, n_cmp_v;
    logic [SLOT_W-1:0]            r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0]            r_slot, n_slot;
    logic [scf_pkg::DLEN_W-1:0]   r_len, n_len;
    logic [NW_W-1:0]              r_nwords, n_nwords;
    logic [DW_W-1:0]              r_widx, n_widx;
    logic                         r_pend, n_pend;
    logic                         r_p_last, n_p_last;
    logic [2:0]                   r_p_tail, n_p_tail;

    // registered read data
    logic [scf_pkg::KEY_BITS-1:0] r_key_q;
    scf_pkg::t_sizes              r_sz_q;
    logic                         r_ev_q;
    logic [scf_pkg::WORD_W-1:0]   r_dq;

    // result queue
    scf_pkg::t_out_item           r_oq [ODEPTH];
    logic [OPTR_W-1:0]            r_ohead;
    logic [OPTR_W-1:0]            r_otail;
    logic [OCNT_W-1:0]            r_ocnt;

    logic                         c_space;
    logic                         c_rd_key;
    logic                         c_rd_data;
    logic                         c_wr_data;
    logic                         c_wr_key;
    logic                         c_push;
    logic                         c_opop;
    scf_pkg::t_out_item           c_item;
    logic [scf_pkg::KEY_BITS-1:0] c_kmask;
    logic [scf_pkg::KLEN_W-1:0]   c_ent_klen;
    logic [scf_pkg::DLEN_W-1:0]   c_ent_dlen;
    logic                         c_match;
    logic                         c_beat_ok;
    logic [scf_pkg::DLEN_W:0]     c_lsum;
    logic                         c_w_last;
    logic [scf_pkg::WORD_W-1:0]   c_tail_word;

    assign c_space   = (r_ocnt + OCNT_W'(r_pend)) < OCNT_W'(ODEPTH);
    assign c_beat_ok = {1'b0, r_beat} < NW_W'(DATA_WORDS);
    assign c_lsum    = {1'b0, c_ent_dlen} + (scf_pkg::DLEN_W + 1)'(7);
    assign c_w_last  = (NW_W'(r_widx) + NW_W'(1)) == r_nwords;
    assign c_opop    = o_out.valid && o_out.ready;

    always_comb begin
        for (int b = 0; b < scf_pkg::KEY_BYTES; b++) begin
            c_kmask[b*8 +: 8] = {8{i_cmd.byte_mask[b]}};
        end
        // an empty slot reads as sizes of zero
        c_ent_klen = r_ev_q ? r_sz_q.klen : '0;
        c_ent_dlen = r_ev_q ? r_sz_q.dlen : '0;
        c_match    = r_cmp_v && (c_ent_klen == i_cmd.key_len) &&
                     (((r_key_q ^ i_cmd.key) & c_kmask) == '0);
        for (int b = 0; b < 8; b++) begin
            c_tail_word[b*8 +: 8] = (r_p_tail == 3'd0 || 3'(b) < r_p_tail) ?
                                    r_dq[b*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_wslot   = r_wslot;
        n_beat    = r_beat;
        n_vld     = r_vld;
        n_idx     = r_idx;
        n_issue   = r_issue;
        n_cmp_v   = 1'b0;
        n_cmp_idx = r_idx;
        n_slot    = r_slot;
        n_len     = r_len;
        n_nwords  = r_nwords;
        n_widx    = r_widx;
        n_pend    = 1'b0;
        n_p_last  = r_p_last;
        n_p_tail  = r_p_tail;
        o_pop     = 1'b0;
        c_push    = 1'b0;
        c_item    = '{status: scf_pkg::ST_OK, out_word: '0, out_len: '0, result_last: 1'b1};
        c_rd_key  = 1'b0;
        c_rd_data = 1'b0;
        c_wr_data = 1'b0;
        c_wr_key  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_vld && !r_pend && c_space) begin
                    unique case (i_cmd.kind) inside
                        scf_pkg::K_BEAT: begin
                            c_wr_data = c_beat_ok;
                            n_beat    = r_beat + scf_pkg::BEAT_W'(1);
                            o_pop     = 1'b1;
                        end
                        scf_pkg::K_COMMIT: begin
                            c_wr_data      = c_beat_ok;
                            c_wr_key       = 1'b1;
                            n_vld[r_wslot] = 1'b1;
                            n_wslot        = (r_wslot == SLOT_W'(ENTRIES - 1)) ?
                                             '0 : r_wslot + SLOT_W'(1);
                            n_beat         = '0;
                            o_pop          = 1'b1;
                            c_push         = 1'b1;
                        end
                        scf_pkg::K_ERR: begin
                            n_beat        = '0;
                            o_pop         = 1'b1;
                            c_push        = 1'b1;
                            c_item.status = scf_pkg::ST_SIZE;
                        end
                        scf_pkg::K_MISS: begin
                            o_pop         = 1'b1;
                            c_push        = 1'b1;
                            c_item.status = scf_pkg::ST_MISS;
                        end
                        scf_pkg::K_FETCH, scf_pkg::K_DELETE: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                            n_issue = 1'b1;
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                // one slot read per cycle, compared in the cycle after its read
                if (r_issue) begin
                    c_rd_key  = 1'b1;
                    n_idx     = r_idx + SLOT_W'(1);
                    n_issue   = r_idx != SLOT_W'(ENTRIES - 1);
                    n_cmp_v   = 1'b1;
                end
                if (c_match) begin
                    n_cmp_v = 1'b0;
                    n_issue = 1'b0;
                    if (i_cmd.kind == scf_pkg::K_DELETE) begin
                        n_vld[r_cmp_idx] = 1'b0;
                        c_push           = 1'b1;
                        o_pop            = 1'b1;
                        n_state          = S_IDLE;
                    end else if (c_ent_dlen == '0) begin
                        c_push  = 1'b1;
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_slot   = r_cmp_idx;
                        n_len    = c_ent_dlen;
                        n_nwords = c_lsum[scf_pkg::DLEN_W-1:3];
                        n_widx   = '0;
                        n_state  = S_STREAM;
                    end
                end else if (r_cmp_v && r_cmp_idx == SLOT_W'(ENTRIES - 1)) begin
                    n_cmp_v       = 1'b0;
                    c_push        = 1'b1;
                    c_item.status = scf_pkg::ST_MISS;
                    o_pop         = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_STREAM: begin
                if (c_space) begin
                    c_rd_data = 1'b1;
                    n_pend    = 1'b1;
                    n_p_last  = c_w_last;
                    n_p_tail  = c_w_last ? r_len[2:0] : 3'd0;
                    n_widx    = r_widx + DW_W'(1);
                    if (c_w_last) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a streamed word is queued in the cycle after its read
        if (r_pend) begin
            c_push = 1'b1;
            c_item = '{status: scf_pkg::ST_OK, out_word: c_tail_word, out_len: r_len,
                       result_last: r_p_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr_key) begin
            key_mem[r_wslot]  <= i_cmd.key;
            size_mem[r_wslot] <= '{klen: i_cmd.key_len, dlen: i_cmd.payload_len};
        end
        if (c_rd_key) begin
            r_key_q <= key_mem[r_idx];
            r_sz_q  <= size_mem[r_idx];
            r_ev_q  <= r_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr_data) begin
            data_mem[{r_wslot, r_beat[DW_W-1:0]}] <= i_cmd.word;
        end
        if (c_rd_data) begin
            r_dq <= data_mem[{r_slot, r_widx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_oq[r_otail] <= c_item;
        end
    end

    assign o_out.valid   = r_ocnt != '0;
    assign o_out.payload = r_oq[r_ohead];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wslot   <= '0;
            r_beat    <= '0;
            r_vld     <= '0;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_cmp_v   <= 1'b0;
            r_cmp_idx <= '0;
            r_slot    <= '0;
            r_len     <= '0;
            r_nwords  <= '0;
            r_widx    <= '0;
            r_pend    <= 1'b0;
            r_p_last  <= 1'b0;
            r_p_tail  <= '0;
            r_ohead   <= '0;
            r_otail   <= '0;
            r_ocnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_wslot   <= n_wslot;
            r_beat    <= n_beat;
            r_vld     <= n_vld;
            r_idx     <= n_idx;
            r_issue   <= n_issue;
            r_cmp_v   <= n_cmp_v;
            r_cmp_idx <= n_cmp_idx;
            r_slot    <= n_slot;
            r_len     <= n_len;
            r_nwords  <= n_nwords;
            r_widx    <= n_widx;
            r_pend    <= n_pend;
            r_p_last  <= n_p_last;
            r_p_tail  <= n_p_tail;
            if (c_push) begin
                r_otail <= r_otail + OPTR_W'(1);
            end
            if (c_opop) begin
                r_ohead <= r_ohead + OPTR_W'(1);
            end
            r_ocnt <= r_ocnt + OCNT_W'(c_push) - OCNT_W'(c_opop);
        end
    end

endmodule

@@ tb/scf_table_checker.sv @@
// Scoreboard for the session cache table: mirrors the table and checks every result word.
module scf_table_checker
    import scf_pkg::*;
#(
    parameter int ENTRIES        = 16,
    parameter int MAX_KEY_BYTES  = 32,
    parameter int MAX_DATA_BYTES = 512
) (
    input  logic i_clk,
    input  logic i_rst_n,
    scf_in_if    i_req,
    scf_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WORDS = (MAX_DATA_BYTES + 7) / 8;

    logic [KEY_BITS-1:0] slot_key  [ENTRIES];
    logic [KLEN_W-1:0]   slot_klen [ENTRIES];
    logic [DLEN_W-1:0]   slot_dlen [ENTRIES];
    logic [WORD_W-1:0]   slot_data [ENTRIES*DATA_WORDS];
    int unsigned         next_slot;
    logic [BEAT_W-1:0]   store_beat;

    t_out_item expected_results[$];
    int        mismatches = 0;
    int        results_seen = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
    endtask

    // lowest slot whose length and first klen key bytes match, -1 on a miss
    function automatic int find_entry(input logic [KEY_BITS-1:0] key,
                                      input logic [KLEN_W-1:0] klen);
        logic [KEY_BITS-1:0] one;
        logic [KEY_BITS-1:0] mask;
        one  = 1;
        mask = (one << (klen * 8)) - one;
        if (klen > MAX_KEY_BYTES)
            return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot_klen[i] == klen && ((slot_key[i] ^ key) & mask) == '0)
                return i;
        return -1;
    endfunction

    function automatic t_out_item make_result(input logic [STAT_W-1:0] st,
                                              input logic [WORD_W-1:0] w,
                                              input logic [DLEN_W-1:0] len,
                                              input logic last);
        t_out_item r;
        r.status      = st;
        r.out_word    = w;
        r.out_len     = len;
        r.result_last = last;
        return r;
    endfunction

    task automatic predict_word(input t_in_item it);
        logic [KEY_BITS-1:0] key;
        logic [WORD_W-1:0]   w;
        int                  hit;
        int unsigned         len;
        int unsigned         words;
        int unsigned         rem;
        key = {it.key_word3, it.key_word2, it.key_word1, it.key_word0};
        case (it.operation)
            OP_STORE: begin
                if (it.key_len > MAX_KEY_BYTES || it.payload_len > MAX_DATA_BYTES) begin
                    // oversized store: beats dropped, error on the last one
                    if (it.beat_last) begin
                        store_beat = '0;
                        expected_results.push_back(make_result(ST_SIZE, '0, '0, 1'b1));
                    end
                end else begin
                    if (store_beat < DATA_WORDS)
                        slot_data[next_slot*DATA_WORDS + store_beat] = it.payload_word;
                    store_beat = store_beat + 1'b1;
                    if (it.beat_last) begin
                        slot_key[next_slot]  = key;
                        slot_klen[next_slot] = it.key_len;
                        slot_dlen[next_slot] = it.payload_len;
                        next_slot  = (next_slot + 1) % ENTRIES;
                        store_beat = '0;
                        expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
                    end
                end
            end
            OP_FETCH: begin
                hit = find_entry(key, it.key_len);
                if (hit < 0) begin
                    expected_results.push_back(make_result(ST_MISS, '0, '0, 1'b1));
                end else begin
                    len = slot_dlen[hit];
                    if (len > MAX_DATA_BYTES)
                        len = MAX_DATA_BYTES;
                    words = (len + 7) / 8;
                    if (words == 0)
                        expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
                    for (int i = 0; i < words; i++) begin
                        w   = slot_data[hit*DATA_WORDS + i];
                        rem = len - i * 8;
                        // bytes past the stored length read as zero
                        if (rem < 8)
                            w &= (64'd1 << (rem * 8)) - 64'd1;
                        expected_results.push_back(
                            make_result(ST_OK, w, DLEN_W'(len), (i + 1) == words));
                    end
                end
            end
            OP_DELETE: begin
                hit = find_entry(key, it.key_len);
                if (hit < 0) begin
                    expected_results.push_back(make_result(ST_MISS, '0, '0, 1'b1));
                end else begin
                    slot_klen[hit] = '0;
                    slot_dlen[hit] = '0;
                    expected_results.push_back(make_result(ST_OK, '0, '0, 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_word(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word: status %0d word %h len %0d last %0b",
                                      got.status, got.out_word, got.out_len, got.result_last));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.out_word !== want.out_word)
            report_mismatch($sformatf("out_word %h, want %h", got.out_word, want.out_word));
        if (got.out_len !== want.out_len)
            report_mismatch($sformatf("out_len %0d, want %0d", got.out_len, want.out_len));
        if (got.result_last !== want.result_last)
            report_mismatch($sformatf("result_last %0b, want %0b",
                                      got.result_last, want.result_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_klen[i] = '0;
                slot_dlen[i] = '0;
            end
            next_slot  = 0;
            store_beat = '0;
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                predict_word(i_req.payload);
            if (i_rsp.valid && i_rsp.ready)
                check_word(i_rsp.payload);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/tb_session_cache_fifo_table.sv @@
// Testbench top for the session cache table: request stimulus, result stalls and verdict.
module tb_session_cache_fifo_table;
    timeunit 1ns;
    timeprecision 1ps;
    import scf_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int MAX_KEY_BYTES  = 32;
    localparam int MAX_DATA_BYTES = 512;
    localparam int ITEM_TARGET    = 480;
    localparam int PHASE_ITEMS    = 120;
    localparam int DRAIN_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 2_000_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [KLEN_W-1:0]   klen;
    } t_key_ref;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    int   item_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    // shadow of the write pointer and of the data words written so far,
    // so that no fetch ever reaches a word that was never stored
    int unsigned       fill_slot;
    logic [BEAT_W-1:0] fill_beat;
    logic [63:0]       filled_words [ENTRIES];
    t_key_ref          known_keys[$];

    scf_in_if  req_ch();
    scf_out_if rsp_ch();

    session_cache_fifo_table #(
        .ENTRIES        (ENTRIES),
        .MAX_KEY_BYTES  (MAX_KEY_BYTES),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    scf_table_checker #(
        .ENTRIES        (ENTRIES),
        .MAX_KEY_BYTES  (MAX_KEY_BYTES),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    function automatic logic [KEY_BITS-1:0] random_key();
        logic [KEY_BITS-1:0] k;
        for (int i = 0; i < KEY_BITS / 32; i++)
            k[i*32 +: 32] = $urandom;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_BITS-1:0] key_mask(input int klen);
        logic [KEY_BITS-1:0] one;
        one = 1;
        return (one << (klen * 8)) - one;
    endfunction

    function automatic t_in_item make_item(input logic [OP_W-1:0] op,
                                           input logic [KEY_BITS-1:0] key,
                                           input int klen, input int dlen,
                                           input logic [WORD_W-1:0] word,
                                           input logic last);
        t_in_item it;
        it.operation    = op;
        it.key_word0    = key[0*WORD_W +: WORD_W];
        it.key_word1    = key[1*WORD_W +: WORD_W];
        it.key_word2    = key[2*WORD_W +: WORD_W];
        it.key_word3    = key[3*WORD_W +: WORD_W];
        it.key_len      = KLEN_W'(klen);
        it.payload_len  = DLEN_W'(dlen);
        it.payload_word = word;
        it.beat_last    = last;
        return it;
    endfunction

    task automatic set_phase(input int p);
        case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    // valid stays high between back-to-back words
    task automatic push_word(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= it;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        if (it.operation != OP_UNUSED)
            item_count++;
    endtask

    task automatic send_beat(input logic [KEY_BITS-1:0] key, input int klen, input int dlen,
                             input logic [WORD_W-1:0] word, input logic last);
        t_key_ref ref_key;
        if (klen <= MAX_KEY_BYTES && dlen <= MAX_DATA_BYTES) begin
            filled_words[fill_slot][fill_beat] = 1'b1;
            fill_beat = fill_beat + 1'b1;
            if (last) begin
                ref_key.key  = key;
                ref_key.klen = KLEN_W'(klen);
                known_keys.push_back(ref_key);
                if (known_keys.size() > 24)
                    void'(known_keys.pop_front());
                fill_slot = (fill_slot + 1) % ENTRIES;
                fill_beat = '0;
            end
        end else if (last) begin
            fill_beat = '0;
        end
        push_word(make_item(OP_STORE, key, klen, dlen, word, last));
    endtask

    task automatic send_lookup(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] key,
                               input int klen);
        push_word(make_item(op, key, klen, $urandom_range(1023), random_word(),
                            1'($urandom_range(1))));
    endtask

    task automatic send_noise();
        push_word(make_item(OP_UNUSED, random_key(), $urandom_range(63), $urandom_range(1023),
                            random_word(), 1'($urandom_range(1))));
    endtask

    task automatic random_lookup(input logic [OP_W-1:0] op);
        t_key_ref            pick;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] m;
        int                  klen;
        int                  roll;
        roll = $urandom_range(99);
        key  = random_key();
        if (known_keys.size() == 0 && (roll < 65 || roll >= 91))
            roll = 70;
        if (roll < 65 || roll >= 91) begin
            pick = known_keys[$urandom_range(known_keys.size() - 1)];
            klen = pick.klen;
            // near miss on length only
            if (roll >= 91)
                klen = (klen == 0 || ($urandom_range(1) && klen < MAX_KEY_BYTES)) ?
                       klen + 1 : klen - 1;
            m   = key_mask(pick.klen);
            key = (pick.key & m) | (key & ~m);
        end else if (roll < 75) begin
            klen = $urandom_range(MAX_KEY_BYTES, 1);
        end else if (roll < 83) begin
            klen = 0;
        end else begin
            klen = $urandom_range(63, MAX_KEY_BYTES + 1);
        end
        send_lookup(op, key, klen);
    endtask

    // stray word inside a store run: lookup, unused code or oversized non-final beat
    task automatic interleave_noise();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            random_lookup(OP_FETCH);
        else if (roll < 60)
            random_lookup(OP_DELETE);
        else if (roll < 80)
            send_noise();
        else
            send_beat(random_key(), $urandom_range(63, MAX_KEY_BYTES + 1),
                      $urandom_range(1023), random_word(), 1'b0);
    endtask

    // fill: 0 random data, 1 all ones, 2 all zeros
    task automatic store_entry(input logic [KEY_BITS-1:0] key, input int klen, input int dlen,
                               input int min_beats, input int fill);
        logic [63:0]       need_mask;
        logic [63:0]       covered;
        logic [WORD_W-1:0] w;
        logic              last;
        int                need;
        int                sent;
        need      = (dlen + 7) / 8;
        need_mask = (need >= 64) ? {64{1'b1}} : ((64'd1 << need) - 64'd1);
        sent      = 0;
        do begin
            if (fill == 0 && $urandom_range(99) < 4)
                interleave_noise();
            sent++;
            covered = filled_words[fill_slot] | (64'd1 << fill_beat);
            last    = sent >= min_beats && (covered & need_mask) == need_mask;
            w       = (fill == 1) ? {WORD_W{1'b1}} : (fill == 2) ? '0 : random_word();
            send_beat(key, klen, dlen, w, last);
        end while (!last);
    endtask

    task automatic random_store();
        t_key_ref            pick;
        logic [KEY_BITS-1:0] key;
        int                  klen;
        int                  dlen;
        int                  need;
        int                  beats;
        int                  roll;
        key  = random_key();
        roll = $urandom_range(99);
        if (roll < 20 && known_keys.size() > 0) begin
            pick = known_keys[$urandom_range(known_keys.size() - 1)];
            key  = pick.key;
            klen = pick.klen;
        end else if (roll < 30) begin
            klen = 0;
        end else if (roll < 45) begin
            klen = MAX_KEY_BYTES;
        end else begin
            klen = $urandom_range(MAX_KEY_BYTES - 1, 1);
        end
        roll = $urandom_range(99);
        if (roll < 10)
            dlen = 0;
        else if (roll < 15)
            dlen = MAX_DATA_BYTES;
        else if (roll < 25)
            dlen = 8 * $urandom_range(8, 1);
        else
            dlen = $urandom_range(64, 1);
        need = (dlen + 7) / 8;
        if (need == 0)
            need = 1;
        roll = $urandom_range(99);
        if (roll < 15)
            beats = $urandom_range(need, 1);
        else if (roll < 25)
            beats = need + $urandom_range(4, 1);
        else if (roll < 27)
            beats = $urandom_range(70, 65);
        else
            beats = need;
        store_entry(key, klen, dlen, beats, 0);
    endtask

    task automatic error_store();
        logic [KEY_BITS-1:0] key;
        int                  klen;
        int                  dlen;
        int                  beats;
        int                  roll;
        key  = random_key();
        roll = $urandom_range(99);
        klen = (roll < 40 || roll >= 80) ? $urandom_range(63, MAX_KEY_BYTES + 1)
                                         : $urandom_range(MAX_KEY_BYTES);
        dlen = (roll >= 40) ? $urandom_range(1023, MAX_DATA_BYTES + 1)
                            : $urandom_range(1023);
        beats = $urandom_range(3, 1);
        for (int i = 0; i < beats; i++)
            send_beat(key, klen, dlen, random_word(), i == beats - 1);
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[session_cache_fifo_table] ERROR");
        $finish;
    end

    initial begin
        logic [KEY_BITS-1:0] k5;
        int                  roll;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        fill_slot      = 0;
        fill_beat      = '0;
        for (int i = 0; i < ENTRIES; i++)
            filled_words[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_phase(3);
        // empty slots match a zero-length key
        send_lookup(OP_FETCH, '0, 0);
        send_lookup(OP_DELETE, '1, 0);
        send_noise();
        // full-width key, last word partly past the length
        store_entry('1, MAX_KEY_BYTES, 13, 2, 1);
        send_lookup(OP_FETCH, '1, MAX_KEY_BYTES);
        send_lookup(OP_FETCH, '1, MAX_KEY_BYTES - 1);
        // zero-length data
        store_entry('0, 1, 0, 1, 2);
        send_lookup(OP_FETCH, random_key() & ~key_mask(1), 1);
        // size errors at the field extremes and just over the limits
        send_beat(random_key(), 63, 1023, {WORD_W{1'b1}}, 1'b0);
        send_beat(random_key(), 63, 1023, '0, 1'b1);
        send_beat(random_key(), MAX_KEY_BYTES + 1, 8, random_word(), 1'b1);
        send_beat(random_key(), MAX_KEY_BYTES, MAX_DATA_BYTES + 1, random_word(), 1'b1);
        // long fetch keys never match
        send_lookup(OP_FETCH, '1, 40);
        send_lookup(OP_FETCH, '1, 63);
        // bytes past key_len are don't-care
        k5 = random_key();
        store_entry(k5, 5, 8, 1, 0);
        send_lookup(OP_FETCH, (k5 & key_mask(5)) | (random_key() & ~key_mask(5)), 5);
        send_lookup(OP_DELETE, (k5 & key_mask(5)) | (random_key() & ~key_mask(5)), 5);
        send_lookup(OP_FETCH, k5, 5);
        send_lookup(OP_DELETE, k5, 5);
        send_lookup(OP_FETCH, random_key(), 0);

        while (item_count < ITEM_TARGET) begin
            set_phase((item_count / PHASE_ITEMS) % 4);
            roll = $urandom_range(99);
            if (roll < 42)
                random_store();
            else if (roll < 72)
                random_lookup(OP_FETCH);
            else if (roll < 84)
                random_lookup(OP_DELETE);
            else if (roll < 95)
                error_store();
            else
                send_noise();
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("[session_cache_fifo_table] OK");
        else
            $display("[session_cache_fifo_table] ERROR");
        $finish;
    end

endmodule
